// ===== rtl/core/upd_pkg.sv =====
// ----------------------------------------------------------------------------
// upd_pkg
// Types, character codes and hex helpers shared by the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam int unsigned PLAN_SLOTS = 3;
    localparam int unsigned QDEPTH     = 2;
    localparam int unsigned QPTR_W     = $clog2(QDEPTH);
    localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        HOLD_NONE  = 2'd0,
        HOLD_PCT   = 2'd1,
        HOLD_DIGIT = 2'd2
    } hold_t;

    typedef struct packed {
        logic [1:0]                  n;
        logic [PLAN_SLOTS-1:0][7:0]  bytes;
        logic                        last;
    } plan_t;

    function automatic logic upd_is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    function automatic logic [3:0] upd_hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if ((c >= 8'h30) && (c <= 8'h39))
        begin
            v = c - 8'h30;
        end
        else if ((c >= 8'h41) && (c <= 8'h46))
        begin
            v = c - 8'h37;
        end
        else if ((c >= 8'h61) && (c <= 8'h66))
        begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

// ===== rtl/core/upd_if.sv =====
// ----------------------------------------------------------------------------
// upd_if
// Stream channels of the URL percent decoder: raw input and decoded output.
// ----------------------------------------------------------------------------
interface upd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       body_end;

    modport source (output valid, output out_byte, output run_last, output body_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input body_end,
                    output ready);
endinterface

// ===== rtl/core/upd_front.sv =====
// ----------------------------------------------------------------------------
// upd_front
// Accepts raw beats, tracks held escape bytes and builds a plan of up to
// three decoded bytes per beat.
// ----------------------------------------------------------------------------
module upd_front (
    input  logic           clk,
    input  logic           rst_n,
    upd_in_if.sink         raw,
    input  logic           q_full,
    output logic           push,
    output upd_pkg::plan_t plan
);
    import upd_pkg::*;

    hold_t           cnt_reg;
    hold_t           cnt_next;
    logic [7:0]      digit_reg;
    logic [7:0]      digit_next;
    logic            accept;
    logic            ok_b;
    logic            fresh;
    logic [1:0]      n;
    logic [3:0][7:0] buf_b;

    assign raw.ready = !q_full;
    assign accept    = raw.valid && !q_full;
    assign ok_b      = upd_is_hex(raw.in_byte);

    always_comb
    begin
        cnt_next   = cnt_reg;
        digit_next = digit_reg;
        fresh      = 1'b0;
        n          = 2'd0;
        buf_b      = '0;
        if (accept)
        begin
            cnt_next = HOLD_NONE;
            unique case (cnt_reg)
                HOLD_NONE:
                begin
                    fresh = 1'b1;
                end
                HOLD_PCT:
                begin
                    if (ok_b)
                    begin
                        cnt_next   = HOLD_DIGIT;
                        digit_next = raw.in_byte;
                    end
                    else
                    begin
                        buf_b[n] = CH_PERCENT;
                        n        = n + 2'd1;
                        fresh    = 1'b1;
                    end
                end
                HOLD_DIGIT:
                begin
                    if (ok_b)
                    begin
                        buf_b[n] = {upd_hex_val(digit_reg), upd_hex_val(raw.in_byte)};
                        n        = n + 2'd1;
                    end
                    else
                    begin
                        buf_b[n] = CH_PERCENT;
                        n        = n + 2'd1;
                        buf_b[n] = digit_reg;
                        n        = n + 2'd1;
                        fresh    = 1'b1;
                    end
                end
                default:
                begin
                    fresh = 1'b1;
                end
            endcase
            if (fresh)
            begin
                if (raw.in_byte == CH_PERCENT)
                begin
                    cnt_next = HOLD_PCT;
                end
                else
                begin
                    buf_b[n] = (raw.in_byte == CH_PLUS) ? CH_SPACE : raw.in_byte;
                    n        = n + 2'd1;
                end
            end
            if (raw.in_last)
            begin
                if (cnt_next == HOLD_PCT)
                begin
                    buf_b[n] = CH_PERCENT;
                    n        = n + 2'd1;
                end
                else if (cnt_next == HOLD_DIGIT)
                begin
                    buf_b[n] = CH_PERCENT;
                    n        = n + 2'd1;
                    buf_b[n] = digit_next;
                    n        = n + 2'd1;
                end
                cnt_next   = HOLD_NONE;
                digit_next = 8'h00;
            end
        end
    end

    assign push       = accept && (n != 2'd0);
    assign plan.n     = n;
    assign plan.bytes = buf_b[PLAN_SLOTS-1:0];
    assign plan.last  = raw.in_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= HOLD_NONE;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (raw.valid && raw.ready && raw.in_last) |=> (cnt_reg == HOLD_NONE))
        else $error("held bytes survive end of body");

    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (plan.n != 2'd0))
        else $error("empty plan pushed");

endmodule

// ===== rtl/core/upd_queue.sv =====
// ----------------------------------------------------------------------------
// upd_queue
// Two-entry plan queue between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
module upd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  upd_pkg::plan_t plan,
    input  logic           pop,
    output logic           full,
    output logic           empty,
    output upd_pkg::plan_t head
);
    import upd_pkg::*;

    plan_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = q_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= plan;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("plan queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("plan queue underflow");

endmodule

// ===== rtl/core/upd_back.sv =====
// ----------------------------------------------------------------------------
// upd_back
// Walks the head plan into the registered output beat, one byte per cycle unless dec stalls.
// ----------------------------------------------------------------------------
module upd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  upd_pkg::plan_t head,
    output logic           pop,
    upd_out_if.source      dec
);
    import upd_pkg::*;

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] byte_reg;
    logic       run_last_reg;
    logic       body_end_reg;
    logic       load;
    logic       take;
    logic       end_of_plan;
    logic [7:0] cur_byte;

    assign load        = !out_valid_reg || dec.ready;
    assign take        = load && !empty;
    assign end_of_plan = (idx_reg == (head.n - 2'd1));
    assign pop         = take && end_of_plan;

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur_byte = head.bytes[0];
            2'd1:    cur_byte = head.bytes[1];
            2'd2:    cur_byte = head.bytes[2];
            default: cur_byte = head.bytes[0];
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = !empty;
        end
        if (take)
        begin
            idx_next = end_of_plan ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg     <= cur_byte;
            run_last_reg <= end_of_plan;
            body_end_reg <= end_of_plan && head.last;
        end
    end

    assign dec.valid    = out_valid_reg;
    assign dec.out_byte = byte_reg;
    assign dec.run_last = run_last_reg;
    assign dec.body_end = body_end_reg;

    a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> (idx_reg == 2'd0))
        else $error("plan index left mid-plan with queue empty");

    a_index_in_plan: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (idx_reg < head.n))
        else $error("plan index beyond plan length");

    a_end_on_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && body_end_reg) |-> run_last_reg)
        else $error("body end without run last");

endmodule

// ===== rtl/core/url_percent_decoder_top.sv =====
// ----------------------------------------------------------------------------
// url_percent_decoder_top
// Form-urlencoded body decoder: '+' to space, '%XX' to a byte, broken
// escapes emitted literally.
//
//   channel  modport  payload                           role
//   raw      sink     in_byte[7:0], in_last             encoded body beats
//   dec      source   out_byte[7:0], run_last, body_end decoded beats
//
// One raw beat per cycle while each beat yields at most one byte and dec.ready is high.
// A beat that yields two or three bytes holds the output until all of them are out;
// the two-entry plan queue absorbs this until it fills.
// Plans pass through the plan queue and then the registered output beat.
// rst_n clears held escape state, the queue and the output valid.
// Output stalls back up into the queue and then into raw.ready.
// ----------------------------------------------------------------------------
module url_percent_decoder_top (
    input  logic      clk,
    input  logic      rst_n,
    upd_in_if.sink    raw,
    upd_out_if.source dec
);
    import upd_pkg::*;

    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;
    plan_t plan;
    plan_t head;

    upd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .raw    (raw),
        .q_full (q_full),
        .push   (push),
        .plan   (plan)
    );

    upd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .plan  (plan),
        .pop   (pop),
        .full  (q_full),
        .empty (q_empty),
        .head  (head)
    );

    upd_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (q_empty),
        .head  (head),
        .pop   (pop),
        .dec   (dec)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the URL percent decoder. Encoded body beats go in with
// random bursts and gaps while the decoded side stalls on its own pattern.
// A scoreboard decodes every accepted raw beat itself and compares each
// decoded beat with the oldest byte and flags it still expects.
// ----------------------------------------------------------------------------
module tb_top;

    import upd_pkg::*;

    localparam int RANDOM_BEATS = 250;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_OFF     = 150;

    typedef struct {
        logic [7:0] data;
        logic       run_last;
        logic       body_end;
    } dec_beat_t;

    class decode_scoreboard;
        dec_beat_t  expected_q[$];
        logic [7:0] step_q[$];
        hold_t      hold;
        logic [7:0] held_digit;
        int         mismatches;

        function new();
            hold       = HOLD_NONE;
            held_digit = 8'h00;
            mismatches = 0;
        endfunction

        function bit digit_value(input logic [7:0] c, output logic [3:0] v);
            v = 4'h0;
            if ((c >= 8'h30) && (c <= 8'h39))
            begin
                v = c[3:0];
                return 1'b1;
            end
            if (((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66)))
            begin
                v = c[3:0] + 4'd9;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void take_fresh(input logic [7:0] b);
            if (b == CH_PERCENT)
            begin
                hold = HOLD_PCT;
            end
            else if (b == CH_PLUS)
            begin
                step_q.push_back(CH_SPACE);
            end
            else
            begin
                step_q.push_back(b);
            end
        endfunction

        function void note_raw(input logic [7:0] b, input logic last);
            logic [3:0] vb;
            logic [3:0] vd;
            bit         okb;
            bit         okd;
            hold_t      was;
            dec_beat_t  e;
            step_q.delete();
            okb  = digit_value(b, vb);
            was  = hold;
            hold = HOLD_NONE;
            case (was)
                HOLD_PCT:
                begin
                    if (okb)
                    begin
                        hold       = HOLD_DIGIT;
                        held_digit = b;
                    end
                    else
                    begin
                        step_q.push_back(CH_PERCENT);
                        take_fresh(b);
                    end
                end
                HOLD_DIGIT:
                begin
                    okd = digit_value(held_digit, vd);
                    if (okb && okd)
                    begin
                        step_q.push_back({vd, vb});
                    end
                    else
                    begin
                        step_q.push_back(CH_PERCENT);
                        step_q.push_back(held_digit);
                        take_fresh(b);
                    end
                end
                default:
                begin
                    take_fresh(b);
                end
            endcase
            if (last)
            begin
                if (hold == HOLD_PCT)
                begin
                    step_q.push_back(CH_PERCENT);
                end
                else if (hold == HOLD_DIGIT)
                begin
                    step_q.push_back(CH_PERCENT);
                    step_q.push_back(held_digit);
                end
                hold       = HOLD_NONE;
                held_digit = 8'h00;
            end
            foreach (step_q[k])
            begin
                e.data     = step_q[k];
                e.run_last = (k == step_q.size() - 1);
                e.body_end = e.run_last && last;
                expected_q.push_back(e);
            end
        endfunction

        function void check_dec(input logic [7:0] b, input logic rl, input logic be);
            dec_beat_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: decoded beat %02h %0b %0b with nothing expected",
                             b, rl, be);
                end
                return;
            end
            e = expected_q.pop_front();
            if ((b !== e.data) || (rl !== e.run_last) || (be !== e.body_end))
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display({"mismatch: expected byte %02h run_last %0b body_end %0b,",
                              " got %02h %0b %0b"},
                             e.data, e.run_last, e.body_end, b, rl, be);
                end
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic hold_req;
    bit   no_gaps;
    int   burst_left;

    upd_in_if  raw_if();
    upd_out_if dec_if();

    decode_scoreboard sb = new();

    url_percent_decoder_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw_if),
        .dec   (dec_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (raw_if.valid && raw_if.ready)
            begin
                sb.note_raw(raw_if.in_byte, raw_if.in_last);
            end
            if (dec_if.valid && dec_if.ready)
            begin
                sb.check_dec(dec_if.out_byte, dec_if.run_last, dec_if.body_end);
            end
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic last);
        raw_if.valid   <= 1'b1;
        raw_if.in_byte <= b;
        raw_if.in_last <= last;
        @(posedge clk);
        while (!raw_if.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic offer(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                raw_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        send_beat(b, last);
    endtask

    task automatic offer_text(input string s, input bit last_at_end);
        for (int i = 0; i < s.len(); i++)
        begin
            offer(s[i], last_at_end && (i == s.len() - 1));
        end
    endtask

    task automatic drain();
        raw_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [7:0] rand_hex();
        case ($urandom_range(0, 2))
            0:       return 8'h30 + 8'($urandom_range(0, 9));
            1:       return 8'h41 + 8'($urandom_range(0, 5));
            default: return 8'h61 + 8'($urandom_range(0, 5));
        endcase
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] near[8] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'h7A, 8'h2B};
        return near[$urandom_range(0, 7)];
    endfunction

    // receiver: segments of full rate, random stalls and dead stretches, plus one hold-off on hold_req
    initial
    begin
        int  seg;
        int  mode;
        bit  hold_done;
        hold_done     = 1'b0;
        dec_if.ready <= 1'b0;
        forever
        begin
            if (hold_req && !hold_done)
            begin
                dec_if.ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
                hold_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            seg  = (mode == 3) ? $urandom_range(1, 8) : $urandom_range(1, 40);
            repeat (seg)
            begin
                case (mode)
                    0:       dec_if.ready <= 1'b1;
                    1:       dec_if.ready <= 1'($urandom_range(0, 1));
                    2:       dec_if.ready <= ($urandom_range(0, 9) != 0);
                    default: dec_if.ready <= 1'b0;
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int  idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((raw_if.valid && raw_if.ready) || (dec_if.valid && dec_if.ready))
            begin
                idle = 0;
            end
            else
            begin
                idle++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic [7:0] tok_q[$];
        int         sent;
        int         r;
        logic       last;
        rst_n           = 1'b0;
        hold_req       <= 1'b0;
        raw_if.valid   <= 1'b0;
        raw_if.in_byte <= 8'h00;
        raw_if.in_last <= 1'b0;
        no_gaps         = 1'b0;
        burst_left      = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_text("%41", 1'b0);
        offer_text("%6f", 1'b0);
        offer_text("%%4G", 1'b0);
        offer_text("%+", 1'b0);
        offer(8'h00, 1'b0);
        offer(8'hFF, 1'b0);
        offer_text("%F", 1'b1);
        offer_text("%", 1'b1);
        offer_text("%z", 1'b1);
        offer_text("%4z", 1'b1);
        offer_text("a", 1'b1);
        drain();

        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            if (sent >= 100 && sent < 160)
            begin
                no_gaps   = 1'b1;
                hold_req <= 1'b1;
            end
            else
            begin
                no_gaps = 1'b0;
            end
            tok_q.delete();
            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                tok_q = '{CH_PERCENT, rand_hex(), rand_hex()};
            end
            else if (r < 45)
            begin
                tok_q = '{CH_PERCENT, rand_hex(), rand_non_hex()};
            end
            else if (r < 52)
            begin
                tok_q = '{CH_PERCENT, rand_non_hex()};
            end
            else if (r < 62)
            begin
                tok_q = '{CH_PLUS};
            end
            else if (r < 68)
            begin
                tok_q = '{CH_PERCENT};
            end
            else
            begin
                tok_q = '{8'($urandom_range(0, 255))};
            end
            foreach (tok_q[i])
            begin
                last = ($urandom_range(0, 15) == 0) || (sent == RANDOM_BEATS - 1);
                offer(tok_q[i], last);
                sent++;
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
